FILE: design/arq_pkg.sv
package arq_pkg;

    // field widths
    localparam int ENERGY_W = 32;
    localparam int COORD_W  = 32;
    localparam int SQ_W     = 66;   // sum of three squared differences
    localparam int LEN_W    = 34;   // step length, Q16.16 plus headroom
    localparam int NPROD_W  = 52;   // coefficient times energy
    localparam int P1_W     = 58;   // length times field
    localparam int DEN_W    = 78;   // length times field times density
    localparam int NLOW_W   = 23;   // low bits of the dividend numerator
    localparam int X_W      = 63;   // reduced stopping power, Q.32, saturated
    localparam int V_W      = 64;   // alpha plus x, Q.32
    localparam int MANT_W   = 32;   // log mantissa, Q1.31
    localparam int FRAC_W   = 30;   // log2 fraction bits
    localparam int EXP_W    = 5;    // log2 integer part
    localparam int LN_W     = 35;   // ln in Q.30
    localparam int F_W      = 24;   // factor, Q2.22
    localparam int VIS_W    = 32;
    localparam int CFG_W    = 24;

    // cell counts along each chain
    localparam int SQ_CELLS  = 34;
    localparam int D1_CELLS  = 63;
    localparam int LOG_CELLS = 30;
    localparam int D2_CELLS  = 24;

    // configuration register indexes
    localparam logic [2:0] CFG_MODEL_SELECT = 3'd0;
    localparam logic [2:0] CFG_DRIFT_FIELD  = 3'd1;
    localparam logic [2:0] CFG_DENSITY      = 3'd2;
    localparam logic [2:0] CFG_BOX_ALPHA    = 3'd3;
    localparam logic [2:0] CFG_BOX_BETA     = 3'd4;
    localparam logic [2:0] CFG_BIRKS_SCALE  = 3'd5;
    localparam logic [2:0] CFG_BIRKS_K      = 3'd6;

    localparam logic        RST_MODEL_SELECT = 1'b0;
    localparam logic [23:0] RST_DRIFT_FIELD  = 24'd32768;
    localparam logic [19:0] RST_DENSITY      = 20'd91095;
    localparam logic [17:0] RST_BOX_ALPHA    = 18'd60948;
    localparam logic [19:0] RST_BOX_BETA     = 20'd13894;
    localparam logic [17:0] RST_BIRKS_SCALE  = 18'd52429;
    localparam logic [19:0] RST_BIRKS_K      = 20'd3185;

    localparam logic            MODEL_BOX   = 1'b0;
    localparam logic            MODEL_BIRKS = 1'b1;

    localparam logic [31:0]     LN2_Q32   = 32'hB172_17F8;
    localparam logic [X_W-1:0]  X_CAP     = {X_W{1'b1}};
    localparam logic [F_W-1:0]  F_MAX     = {F_W{1'b1}};
    localparam logic [F_W-1:0]  F_FLOOR   = 24'd4;
    localparam logic [F_W-1:0]  F_ONE     = 24'h40_0000;
    localparam logic [17:0]     ALPHA_ONE = 18'h1_0000;
    localparam logic [V_W-1:0]  V_ONE     = 64'h1_0000_0000;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic                zero;
    } sqrt_side_t;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic                zero;
        logic                xsat;
        logic                dzero;
        logic [NLOW_W-1:0]   nlow;
    } div1_side_t;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic                zero;
        logic [X_W-1:0]      x;
        logic                xzero;
        logic                vsmall;
        logic [EXP_W-1:0]    expo;
    } log_side_t;

    typedef struct packed {
        logic [ENERGY_W-1:0] energy;
        logic                zero;
        logic                fsat;
        logic                xzero;
        logic                vsmall;
    } div2_side_t;

    function automatic logic [COORD_W-1:0] abs_diff(
        input logic signed [COORD_W-1:0] a,
        input logic signed [COORD_W-1:0] b
    );
        logic [COORD_W:0] d;
        logic [COORD_W:0] mag;
        d   = {b[COORD_W-1], b} - {a[COORD_W-1], a};
        mag = d[COORD_W] ? (~d + 1'b1) : d;
        return mag[COORD_W-1:0];
    endfunction

endpackage

FILE: design/arq_step_if.sv
interface arq_step_if
    import arq_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [ENERGY_W-1:0]        energy;
    logic signed [COORD_W-1:0]  start_x;
    logic signed [COORD_W-1:0]  start_y;
    logic signed [COORD_W-1:0]  start_z;
    logic signed [COORD_W-1:0]  end_x;
    logic signed [COORD_W-1:0]  end_y;
    logic signed [COORD_W-1:0]  end_z;

    modport source (
        output valid, energy, start_x, start_y, start_z, end_x, end_y, end_z,
        input  ready
    );
    modport sink (
        input  valid, energy, start_x, start_y, start_z, end_x, end_y, end_z,
        output ready
    );
endinterface

FILE: design/arq_result_if.sv
interface arq_result_if
    import arq_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [VIS_W-1:0]   visible_energy;
    logic               zero_step;

    modport source (
        output valid, visible_energy, zero_step,
        input  ready
    );
    modport sink (
        input  valid, visible_energy, zero_step,
        output ready
    );
endinterface

FILE: design/argon_recombination_quench_unit.sv
// recombination quench for ionization steps in liquid argon
//
// step channel: one item per simulation step, deposited energy plus the
// start and end points. result channel: visible energy and a flag for a
// zero-length step. both channels are valid/ready.
// configuration: cfg_wen writes cfg_data into register cfg_index; registers
// are model select, field, density, box alpha/beta, birks scale and k.
// write them only while no item is in flight.
//
// throughput: one item per cycle while the receiver does not stall, fully pipelined.
// pipeline: 34 square-root cells, 63 division cells for the stopping power,
// 30 log squaring cells and 24 division cells for the factor, plus 14
// arithmetic stages and the output register.
//
// reset empties the pipeline and loads the default configuration.
// when the receiver stalls, the output register holds its item and the
// pipeline freezes; step.ready stays high while the last stage is empty,
// so bubbles are squeezed out before the input is held off.
module argon_recombination_quench_unit
    import arq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    arq_step_if.sink          step,
    arq_result_if.source      result,
    input  logic              cfg_wen,
    input  logic [2:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data
);

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    logic        model_select_reg;
    logic [23:0] drift_field_reg;
    logic [19:0] density_reg;
    logic [17:0] box_alpha_reg;
    logic [19:0] box_beta_reg;
    logic [17:0] birks_scale_reg;
    logic [19:0] birks_k_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            model_select_reg <= RST_MODEL_SELECT;
            drift_field_reg  <= RST_DRIFT_FIELD;
            density_reg      <= RST_DENSITY;
            box_alpha_reg    <= RST_BOX_ALPHA;
            box_beta_reg     <= RST_BOX_BETA;
            birks_scale_reg  <= RST_BIRKS_SCALE;
            birks_k_reg      <= RST_BIRKS_K;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_MODEL_SELECT: model_select_reg <= cfg_data[0];
                CFG_DRIFT_FIELD:  drift_field_reg  <= cfg_data[23:0];
                CFG_DENSITY:      density_reg      <= cfg_data[19:0];
                CFG_BOX_ALPHA:    box_alpha_reg    <= cfg_data[17:0];
                CFG_BOX_BETA:     box_beta_reg     <= cfg_data[19:0];
                CFG_BIRKS_SCALE:  birks_scale_reg  <= cfg_data[17:0];
                CFG_BIRKS_K:      birks_k_reg      <= cfg_data[19:0];
                default:          ;   // unused indexes are ignored
            endcase
        end
    end

    // ---------------------------------------------------------------
    // flow control: the whole pipe moves together unless the output
    // register is full, stalled, and the last stage holds an item
    // ---------------------------------------------------------------
    logic adv;
    logic out_valid_reg;
    logic v14_reg;

    assign adv        = !out_valid_reg || result.ready || !v14_reg;
    assign step.ready = adv;

    // ---------------------------------------------------------------
    // front: differences, squares, sum
    // ---------------------------------------------------------------
    logic                v1_reg, v2_reg, v3_reg;
    logic [ENERGY_W-1:0] e1_reg, e2_reg, e3_reg;
    logic [COORD_W-1:0]  ax1_reg, ay1_reg, az1_reg;
    logic [63:0]         sx2_reg, sy2_reg, sz2_reg;
    logic [SQ_W-1:0]     s3_reg, s3_next;
    logic                zr3_reg;

    always_comb
    begin
        s3_next = SQ_W'(sx2_reg) + SQ_W'(sy2_reg) + SQ_W'(sz2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e1_reg  <= step.energy;
            ax1_reg <= abs_diff(step.start_x, step.end_x);
            ay1_reg <= abs_diff(step.start_y, step.end_y);
            az1_reg <= abs_diff(step.start_z, step.end_z);
            e2_reg  <= e1_reg;
            sx2_reg <= ax1_reg * ax1_reg;
            sy2_reg <= ay1_reg * ay1_reg;
            sz2_reg <= az1_reg * az1_reg;
            e3_reg  <= e2_reg;
            s3_reg  <= s3_next;
            zr3_reg <= (s3_next == '0);
        end
    end

    // ---------------------------------------------------------------
    // square root chain, one root bit per cell, msb first
    // ---------------------------------------------------------------
    logic             sq_valid [0:SQ_CELLS];
    logic [SQ_W-1:0]  sq_rem   [0:SQ_CELLS];
    logic [LEN_W-1:0] sq_root  [0:SQ_CELLS];
    sqrt_side_t       sq_side  [0:SQ_CELLS];

    assign sq_valid[0]       = v3_reg;
    assign sq_rem[0]         = s3_reg;
    assign sq_root[0]        = '0;
    assign sq_side[0].energy = e3_reg;
    assign sq_side[0].zero   = zr3_reg;

    for (genvar i = 0; i < SQ_CELLS; i++)
    begin : g_sqrt
        arq_sqrt_cell #(
            .SW  ($bits(sqrt_side_t)),
            .BIT (SQ_CELLS - 1 - i)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (sq_valid[i]),
            .rem_in    (sq_rem[i]),
            .root_in   (sq_root[i]),
            .side_in   (sq_side[i]),
            .out_valid (sq_valid[i+1]),
            .rem_out   (sq_rem[i+1]),
            .root_out  (sq_root[i+1]),
            .side_out  (sq_side[i+1])
        );
    end

    // ---------------------------------------------------------------
    // denominator length*field*density and numerator coef*energy
    // ---------------------------------------------------------------
    logic                v4_reg, v5_reg, v6_reg, v7_reg;
    logic [ENERGY_W-1:0] e4_reg, e5_reg, e6_reg;
    logic                zr4_reg, zr5_reg, zr6_reg;
    logic [P1_W-1:0]     p1_4_reg;
    logic [NPROD_W-1:0]  np4_reg, np5_reg, np6_reg;
    logic [48:0]         dlo5_reg, dhi5_reg;
    logic [DEN_W-1:0]    den6_reg, den7_reg;
    logic [28:0]         r07_reg;
    div1_side_t          side7_reg;
    logic [19:0]         coef;
    logic                d1_dzero;
    logic                d1_fits;

    always_comb
    begin
        coef     = (model_select_reg == MODEL_BIRKS) ? birks_k_reg : box_beta_reg;
        d1_dzero = (den6_reg == '0);
        // quotient overflows past 63 bits when the top dividend bits reach den
        d1_fits  = DEN_W'(np6_reg[NPROD_W-1:NLOW_W]) < den6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e4_reg   <= sq_side[SQ_CELLS].energy;
            zr4_reg  <= sq_side[SQ_CELLS].zero;
            p1_4_reg <= sq_root[SQ_CELLS] * drift_field_reg;
            np4_reg  <= coef * sq_side[SQ_CELLS].energy;

            e5_reg   <= e4_reg;
            zr5_reg  <= zr4_reg;
            np5_reg  <= np4_reg;
            dlo5_reg <= p1_4_reg[28:0] * density_reg;
            dhi5_reg <= p1_4_reg[P1_W-1:29] * density_reg;

            e6_reg   <= e5_reg;
            zr6_reg  <= zr5_reg;
            np6_reg  <= np5_reg;
            den6_reg <= DEN_W'(dlo5_reg) + (DEN_W'(dhi5_reg) << 29);

            den7_reg         <= den6_reg;
            r07_reg          <= np6_reg[NPROD_W-1:NLOW_W];
            side7_reg.energy <= e6_reg;
            side7_reg.zero   <= zr6_reg;
            side7_reg.xsat   <= d1_dzero ? (np6_reg != '0) : !d1_fits;
            side7_reg.dzero  <= d1_dzero;
            side7_reg.nlow   <= np6_reg[NLOW_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // stopping-power division chain, 63 quotient bits
    // dividend is np << 40, so only the nlow bits are nonzero below
    // ---------------------------------------------------------------
    logic             d1_valid [0:D1_CELLS];
    logic [DEN_W-1:0] d1_r     [0:D1_CELLS];
    logic [DEN_W-1:0] d1_d     [0:D1_CELLS];
    logic [X_W-1:0]   d1_q     [0:D1_CELLS];
    div1_side_t       d1_side  [0:D1_CELLS];

    assign d1_valid[0] = v7_reg;
    assign d1_r[0]     = DEN_W'(r07_reg);
    assign d1_d[0]     = den7_reg;
    assign d1_q[0]     = '0;
    assign d1_side[0]  = side7_reg;

    for (genvar i = 0; i < D1_CELLS; i++)
    begin : g_div1
        localparam int POS = D1_CELLS - 1 - i;
        logic dbit;
        if (POS >= 40)
        begin : g_live
            assign dbit = d1_side[i].nlow[POS-40];
        end
        else
        begin : g_zero
            assign dbit = 1'b0;
        end

        arq_div_cell #(
            .DW (DEN_W),
            .QW (X_W),
            .SW ($bits(div1_side_t))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (d1_valid[i]),
            .r_in      (d1_r[i]),
            .d_in      (d1_d[i]),
            .q_in      (d1_q[i]),
            .bit_in    (dbit),
            .side_in   (d1_side[i]),
            .out_valid (d1_valid[i+1]),
            .r_out     (d1_r[i+1]),
            .d_out     (d1_d[i+1]),
            .q_out     (d1_q[i+1]),
            .side_out  (d1_side[i+1])
        );
    end

    // ---------------------------------------------------------------
    // x, alpha + x, leading one, mantissa
    // ---------------------------------------------------------------
    logic                v8_reg, v9_reg, v10_reg;
    logic [ENERGY_W-1:0] e8_reg, e9_reg;
    logic                zr8_reg, zr9_reg;
    logic [X_W-1:0]      x8_reg, x9_reg, x_next;
    logic [V_W-1:0]      v8v_reg, v9v_reg, vsum_next;
    logic                xz8_reg, xz9_reg, vs8_reg, vs9_reg;
    logic [5:0]          top_next, top9_reg, shamt;
    logic [V_W-1:0]      shifted;
    logic [MANT_W-1:0]   m10_reg;
    log_side_t           side10_reg;

    always_comb
    begin
        priority if (d1_side[D1_CELLS].xsat)
        begin
            x_next = X_CAP;
        end
        else if (d1_side[D1_CELLS].dzero)
        begin
            x_next = '0;
        end
        else
        begin
            x_next = d1_q[D1_CELLS];
        end
        vsum_next = (V_W'(box_alpha_reg) << 16) + V_W'(x_next);
    end

    always_comb
    begin
        top_next = '0;
        for (int i = 0; i < V_W; i++)
        begin
            if (v8v_reg[i])
            begin
                top_next = 6'(i);
            end
        end
    end

    always_comb
    begin
        shamt   = top9_reg - 6'd31;
        shifted = v9v_reg >> shamt;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            e8_reg  <= d1_side[D1_CELLS].energy;
            zr8_reg <= d1_side[D1_CELLS].zero;
            x8_reg  <= x_next;
            v8v_reg <= vsum_next;
            xz8_reg <= (x_next == '0);
            vs8_reg <= (vsum_next <= V_ONE);

            e9_reg   <= e8_reg;
            zr9_reg  <= zr8_reg;
            x9_reg   <= x8_reg;
            v9v_reg  <= v8v_reg;
            xz9_reg  <= xz8_reg;
            vs9_reg  <= vs8_reg;
            top9_reg <= top_next;

            m10_reg           <= shifted[MANT_W-1:0];
            side10_reg.energy <= e9_reg;
            side10_reg.zero   <= zr9_reg;
            side10_reg.x      <= x9_reg;
            side10_reg.xzero  <= xz9_reg;
            side10_reg.vsmall <= vs9_reg;
            side10_reg.expo   <= top9_reg[EXP_W-1:0];   // top - 32
        end
    end

    // ---------------------------------------------------------------
    // log2 fraction by repeated squaring, one bit per cell
    // ---------------------------------------------------------------
    logic              lg_valid [0:LOG_CELLS];
    logic [MANT_W-1:0] lg_m     [0:LOG_CELLS];
    logic [FRAC_W-1:0] lg_frac  [0:LOG_CELLS];
    log_side_t         lg_side  [0:LOG_CELLS];

    assign lg_valid[0] = v10_reg;
    assign lg_m[0]     = m10_reg;
    assign lg_frac[0]  = '0;
    assign lg_side[0]  = side10_reg;

    for (genvar i = 0; i < LOG_CELLS; i++)
    begin : g_log
        arq_log_cell #(
            .SW ($bits(log_side_t))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (lg_valid[i]),
            .m_in      (lg_m[i]),
            .frac_in   (lg_frac[i]),
            .side_in   (lg_side[i]),
            .out_valid (lg_valid[i+1]),
            .m_out     (lg_m[i+1]),
            .frac_out  (lg_frac[i+1]),
            .side_out  (lg_side[i+1])
        );
    end

    // ---------------------------------------------------------------
    // ln = log2 * ln2, then set up the factor division
    // box: ln * 2^24 / x      birks: scale * 2^38 / (2^32 + x)
    // ---------------------------------------------------------------
    logic                v11_reg, v12_reg;
    logic [LN_W+31:0]    ln_prod;
    logic [LN_W-1:0]     ln11_reg;
    log_side_t           side11_reg;
    logic [V_W-1:0]      r012_reg, d12_reg, r0_next, d_next;
    logic                fsat_next;
    div2_side_t          side12_reg;

    always_comb
    begin
        ln_prod = {lg_side[LOG_CELLS].expo, lg_frac[LOG_CELLS]} * LN2_Q32;
    end

    always_comb
    begin
        if (model_select_reg == MODEL_BIRKS)
        begin
            r0_next   = V_W'(birks_scale_reg) << 14;
            d_next    = V_ONE + V_W'(side11_reg.x);
            fsat_next = 1'b0;
        end
        else
        begin
            r0_next   = V_W'(ln11_reg);
            d_next    = V_W'(side11_reg.x);
            fsat_next = V_W'(ln11_reg) >= V_W'(side11_reg.x);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ln11_reg   <= ln_prod[LN_W+31:32];
            side11_reg <= lg_side[LOG_CELLS];

            r012_reg          <= r0_next;
            d12_reg           <= d_next;
            side12_reg.energy <= side11_reg.energy;
            side12_reg.zero   <= side11_reg.zero;
            side12_reg.fsat   <= fsat_next;
            side12_reg.xzero  <= side11_reg.xzero;
            side12_reg.vsmall <= side11_reg.vsmall;
        end
    end

    // ---------------------------------------------------------------
    // factor division chain, 24 quotient bits, zeros shifted in
    // ---------------------------------------------------------------
    logic           d2_valid [0:D2_CELLS];
    logic [V_W-1:0] d2_r     [0:D2_CELLS];
    logic [V_W-1:0] d2_d     [0:D2_CELLS];
    logic [F_W-1:0] d2_q     [0:D2_CELLS];
    div2_side_t     d2_side  [0:D2_CELLS];

    assign d2_valid[0] = v12_reg;
    assign d2_r[0]     = r012_reg;
    assign d2_d[0]     = d12_reg;
    assign d2_q[0]     = '0;
    assign d2_side[0]  = side12_reg;

    for (genvar i = 0; i < D2_CELLS; i++)
    begin : g_div2
        arq_div_cell #(
            .DW (V_W),
            .QW (F_W),
            .SW ($bits(div2_side_t))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (d2_valid[i]),
            .r_in      (d2_r[i]),
            .d_in      (d2_d[i]),
            .q_in      (d2_q[i]),
            .bit_in    (1'b0),
            .side_in   (d2_side[i]),
            .out_valid (d2_valid[i+1]),
            .r_out     (d2_r[i+1]),
            .d_out     (d2_d[i+1]),
            .q_out     (d2_q[i+1]),
            .side_out  (d2_side[i+1])
        );
    end

    // ---------------------------------------------------------------
    // factor select, energy * factor, saturate
    // ---------------------------------------------------------------
    logic                v13_reg;
    logic [F_W-1:0]      f13_reg, f_next;
    logic [ENERGY_W-1:0] e13_reg;
    logic                zr13_reg, zr14_reg;
    logic [55:0]         prod14_reg;
    logic [VIS_W-1:0]    vis_reg, vis_next;
    logic                zero_out_reg;
    div2_side_t          d2_last;

    assign d2_last = d2_side[D2_CELLS];

    always_comb
    begin
        if (model_select_reg == MODEL_BIRKS)
        begin
            f_next = d2_q[D2_CELLS];
        end
        else
        begin
            priority if (d2_last.xzero)
            begin
                // no stopping power: limit of ln(alpha + x) / x
                priority if (box_alpha_reg > ALPHA_ONE)
                begin
                    f_next = F_MAX;
                end
                else if (box_alpha_reg == ALPHA_ONE)
                begin
                    f_next = F_ONE;
                end
                else
                begin
                    f_next = F_FLOOR;
                end
            end
            else if (d2_last.vsmall)
            begin
                f_next = F_FLOOR;   // log not positive
            end
            else if (d2_last.fsat)
            begin
                f_next = F_MAX;
            end
            else if (d2_q[D2_CELLS] < F_FLOOR)
            begin
                f_next = F_FLOOR;
            end
            else
            begin
                f_next = d2_q[D2_CELLS];
            end
        end
    end

    always_comb
    begin
        priority if (zr14_reg)
        begin
            vis_next = '0;
        end
        else if (prod14_reg[55:54] != 2'b00)
        begin
            vis_next = {VIS_W{1'b1}};
        end
        else
        begin
            vis_next = prod14_reg[53:22];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            f13_reg    <= f_next;
            e13_reg    <= d2_last.energy;
            zr13_reg   <= d2_last.zero;
            prod14_reg <= e13_reg * f13_reg;
            zr14_reg   <= zr13_reg;
        end
        if (!out_valid_reg || result.ready)
        begin
            vis_reg      <= vis_next;
            zero_out_reg <= zr14_reg;
        end
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            v9_reg        <= 1'b0;
            v10_reg       <= 1'b0;
            v11_reg       <= 1'b0;
            v12_reg       <= 1'b0;
            v13_reg       <= 1'b0;
            v14_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                v1_reg  <= step.valid;
                v2_reg  <= v1_reg;
                v3_reg  <= v2_reg;
                v4_reg  <= sq_valid[SQ_CELLS];
                v5_reg  <= v4_reg;
                v6_reg  <= v5_reg;
                v7_reg  <= v6_reg;
                v8_reg  <= d1_valid[D1_CELLS];
                v9_reg  <= v8_reg;
                v10_reg <= v9_reg;
                v11_reg <= lg_valid[LOG_CELLS];
                v12_reg <= v11_reg;
                v13_reg <= d2_valid[D2_CELLS];
                v14_reg <= v13_reg;
            end
            if (!out_valid_reg || result.ready)
            begin
                out_valid_reg <= v14_reg;
            end
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.visible_energy = vis_reg;
    assign result.zero_step      = zero_out_reg;

`ifndef NO_ASSERTIONS
    // input is held off only behind a full, stalled output register
    a_ready_only_on_stall: assert property (
        @(posedge clk) disable iff (!rst_n)
        !step.ready |-> (result.valid && !result.ready)
    ) else $error("step.ready low without an output stall");

    // a step with nonzero extent has a nonzero length
    a_len_nonzero: assert property (
        @(posedge clk) disable iff (!rst_n)
        (sq_valid[SQ_CELLS] && !sq_side[SQ_CELLS].zero) |-> (sq_root[SQ_CELLS] != '0)
    ) else $error("zero length for a nonzero step");

    // box model factor never falls under the floor
    a_box_floor: assert property (
        @(posedge clk) disable iff (!rst_n)
        (v13_reg && (model_select_reg == MODEL_BOX) && !zr13_reg) |-> (f13_reg >= F_FLOOR)
    ) else $error("box factor below floor");

    // a zero-length step always reports zero visible energy
    a_zero_step_result: assert property (
        @(posedge clk) disable iff (!rst_n)
        (result.valid && result.zero_step) |-> (result.visible_energy == '0)
    ) else $error("zero step with nonzero energy");
`endif

endmodule

FILE: design/arq_sqrt_cell.sv
module arq_sqrt_cell
    import arq_pkg::*;
#(
    parameter int SW  = 1,
    parameter int BIT = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  logic [SQ_W-1:0]  rem_in,
    input  logic [LEN_W-1:0] root_in,
    input  logic [SW-1:0]    side_in,
    output logic             out_valid,
    output logic [SQ_W-1:0]  rem_out,
    output logic [LEN_W-1:0] root_out,
    output logic [SW-1:0]    side_out
);
    localparam int TW = SQ_W + 2;

    logic [TW-1:0]    trial;
    logic             take;
    logic             valid_reg;
    logic [SQ_W-1:0]  rem_reg, rem_next;
    logic [LEN_W-1:0] root_reg, root_next;
    logic [SW-1:0]    side_reg;

    // trial = (2*root + 2^bit) * 2^bit
    always_comb
    begin
        trial     = (TW'(root_in) << (BIT + 1)) | (TW'(1) << (2 * BIT));
        take      = {2'b00, rem_in} >= trial;
        rem_next  = take ? (rem_in - trial[SQ_W-1:0]) : rem_in;
        root_next = take ? (root_in | (LEN_W'(1) << BIT)) : root_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign rem_out   = rem_reg;
    assign root_out  = root_reg;
    assign side_out  = side_reg;
endmodule

FILE: design/arq_div_cell.sv
module arq_div_cell #(
    parameter int DW = 8,
    parameter int QW = 8,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] r_in,
    input  logic [DW-1:0] d_in,
    input  logic [QW-1:0] q_in,
    input  logic          bit_in,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [DW-1:0] r_out,
    output logic [DW-1:0] d_out,
    output logic [QW-1:0] q_out,
    output logic [SW-1:0] side_out
);
    logic [DW:0]   shifted;
    logic [DW:0]   diff;
    logic          take;
    logic          valid_reg;
    logic [DW-1:0] r_reg, r_next;
    logic [DW-1:0] d_reg;
    logic [QW-1:0] q_reg, q_next;
    logic [SW-1:0] side_reg;

    // one restoring step: bring in the next dividend bit, subtract if it fits
    always_comb
    begin
        shifted = {r_in, bit_in};
        diff    = shifted - {1'b0, d_in};
        take    = shifted >= {1'b0, d_in};
        r_next  = take ? diff[DW-1:0] : shifted[DW-1:0];
        q_next  = {q_in[QW-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg    <= r_next;
            d_reg    <= d_in;
            q_reg    <= q_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign r_out     = r_reg;
    assign d_out     = d_reg;
    assign q_out     = q_reg;
    assign side_out  = side_reg;
endmodule

FILE: design/arq_log_cell.sv
module arq_log_cell
    import arq_pkg::*;
#(
    parameter int SW = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [MANT_W-1:0] m_in,
    input  logic [FRAC_W-1:0] frac_in,
    input  logic [SW-1:0]     side_in,
    output logic              out_valid,
    output logic [MANT_W-1:0] m_out,
    output logic [FRAC_W-1:0] frac_out,
    output logic [SW-1:0]     side_out
);
    logic [2*MANT_W-1:0] square;
    logic [MANT_W:0]     scaled;
    logic                valid_reg;
    logic [MANT_W-1:0]   m_reg, m_next;
    logic [FRAC_W-1:0]   frac_reg, frac_next;
    logic [SW-1:0]       side_reg;

    // square the mantissa, renormalize on overflow past 2.0
    always_comb
    begin
        square    = m_in * m_in;
        scaled    = square[2*MANT_W-1:MANT_W-1];
        m_next    = scaled[MANT_W] ? scaled[MANT_W:1] : scaled[MANT_W-1:0];
        frac_next = {frac_in[FRAC_W-2:0], scaled[MANT_W]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_reg    <= m_next;
            frac_reg <= frac_next;
            side_reg <= side_in;
        end
    end

    assign out_valid = valid_reg;
    assign m_out     = m_reg;
    assign frac_out  = frac_reg;
    assign side_out  = side_reg;
endmodule

FILE: sim/arq_checker.sv
module arq_checker
    import arq_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    arq_step_if               step,
    arq_result_if             result,
    input  logic              cfg_wen,
    input  logic [2:0]        cfg_index,
    input  logic [CFG_W-1:0]  cfg_data,
    output int                mismatches,
    output int                outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [VIS_W-1:0] visible_energy;
        logic             zero_step;
    } quench_t;

    quench_t quench_q[$];

    logic        sel_model;
    logic [23:0] field_r;
    logic [19:0] dens_r;
    logic [17:0] alpha_r;
    logic [19:0] beta_r;
    logic [17:0] scale_r;
    logic [19:0] kb_r;

    function automatic logic [63:0] diff_mag(logic signed [31:0] a, logic signed [31:0] b);
        logic signed [33:0] d;
        d = 34'(b) - 34'(a);
        return (d < 0) ? 64'(-d) : 64'(d);
    endfunction

    function automatic logic [63:0] isqrt(logic [127:0] s);
        logic [63:0]  r;
        logic [63:0]  c;
        logic [127:0] cc;
        r = 0;
        for (int b = 33; b >= 0; b--)
        begin
            c  = r | (64'd1 << b);
            cc = 128'(c) * 128'(c);
            if (cc <= s)
                r = c;
        end
        return r;
    endfunction

    function automatic logic [63:0] log2_fixed(logic [63:0] v);
        int          top;
        logic [63:0] m;
        logic [63:0] frac;
        top  = 63;
        frac = 0;
        while (top > 0 && !v[top])
            top--;
        m = (top > 31) ? (v >> (top - 31)) : (v << (31 - top));
        for (int i = 29; i >= 0; i--)
        begin
            m = (m * m) >> 31;
            if (m >= 64'h1_0000_0000)
            begin
                frac |= 64'd1 << i;
                m = m >> 1;
            end
        end
        return (64'(top - 32) << 30) + frac;
    endfunction

    function automatic logic [63:0] box_fac(logic [63:0] x);
        logic [63:0]  v;
        logic [127:0] p;
        logic [63:0]  ln;
        logic [63:0]  f;
        if (x == 0)
        begin
            if (alpha_r > ALPHA_ONE) return 64'(F_MAX);
            if (alpha_r == ALPHA_ONE) return 64'(F_ONE);
            return 64'(F_FLOOR);
        end
        v = (64'(alpha_r) << 16) + x;
        if (v <= V_ONE)
            return 64'(F_FLOOR);
        p  = 128'(log2_fixed(v)) * 128'(LN2_Q32);
        ln = 64'(p >> 32);
        f  = (ln << 24) / x;
        if (f > 64'(F_MAX)) f = 64'(F_MAX);
        if (f < 64'(F_FLOOR)) f = 64'(F_FLOOR);
        return f;
    endfunction

    function automatic quench_t quench_predict();
        quench_t      o;
        logic [127:0] s;
        logic [63:0]  d;
        logic [63:0]  len;
        logic [127:0] den;
        logic [127:0] num;
        logic [127:0] q;
        logic [63:0]  x;
        logic [63:0]  f;
        logic [63:0]  vis;
        logic [63:0]  coef;
        d = diff_mag(step.start_x, step.end_x); s = 128'(d) * 128'(d);
        d = diff_mag(step.start_y, step.end_y); s += 128'(d) * 128'(d);
        d = diff_mag(step.start_z, step.end_z); s += 128'(d) * 128'(d);
        if (s == 0)
        begin
            o.visible_energy = 0;
            o.zero_step      = 1'b1;
            return o;
        end
        len  = isqrt(s);
        den  = 128'(len) * 128'(field_r) * 128'(dens_r);
        coef = (sel_model == MODEL_BIRKS) ? 64'(kb_r) : 64'(beta_r);
        num  = (128'(coef) * 128'(step.energy)) << 40;
        if (den == 0)
            x = (num != 0) ? 64'(X_CAP) : 64'd0;
        else
        begin
            q = num / den;
            x = (q > 128'(X_CAP)) ? 64'(X_CAP) : 64'(q);
        end
        if (sel_model == MODEL_BIRKS)
        begin
            f = (64'(scale_r) << 38) / (64'h1_0000_0000 + x);
            if (f > 64'(F_MAX)) f = 64'(F_MAX);
        end
        else
            f = box_fac(x);
        vis = (64'(step.energy) * f) >> 22;
        o.visible_energy = (vis > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : vis[31:0];
        o.zero_step      = 1'b0;
        return o;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    assign outstanding = quench_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        quench_t e;
        if (!rst_n)
        begin
            sel_model  = RST_MODEL_SELECT;
            field_r    = RST_DRIFT_FIELD;
            dens_r     = RST_DENSITY;
            alpha_r    = RST_BOX_ALPHA;
            beta_r     = RST_BOX_BETA;
            scale_r    = RST_BIRKS_SCALE;
            kb_r       = RST_BIRKS_K;
            mismatches = 0;
            quench_q.delete();
        end
        else
        begin
            if (step.valid && step.ready)
                quench_q.push_back(quench_predict());
            if (result.valid && result.ready)
            begin
                if (quench_q.size() == 0)
                    report("unexpected item", 64'(result.visible_energy), 64'd0);
                else
                begin
                    e = quench_q.pop_front();
                    if (result.visible_energy !== e.visible_energy)
                        report("visible_energy", 64'(result.visible_energy),
                               64'(e.visible_energy));
                    if (result.zero_step !== e.zero_step)
                        report("zero_step", 64'(result.zero_step), 64'(e.zero_step));
                end
            end
            if (cfg_wen)
            begin
                case (cfg_index)
                    CFG_MODEL_SELECT: sel_model = cfg_data[0];
                    CFG_DRIFT_FIELD:  field_r   = cfg_data[23:0];
                    CFG_DENSITY:      dens_r    = cfg_data[19:0];
                    CFG_BOX_ALPHA:    alpha_r   = cfg_data[17:0];
                    CFG_BOX_BETA:     beta_r    = cfg_data[19:0];
                    CFG_BIRKS_SCALE:  scale_r   = cfg_data[17:0];
                    CFG_BIRKS_K:      kb_r      = cfg_data[19:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

FILE: sim/tb_top.sv
module tb_top;
    import arq_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 600000;
    localparam int DRAIN       = 200;

    logic              clk;
    logic              rst_n;
    logic              cfg_wen;
    logic [2:0]        cfg_index;
    logic [CFG_W-1:0]  cfg_data;
    int                mismatches;
    int                outstanding;
    int                cycles = 0;

    arq_step_if   step ();
    arq_result_if result ();

    argon_recombination_quench_unit i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .result    (result),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    arq_checker i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .result      (result),
        .cfg_wen     (cfg_wen),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // 4 ns clock
    initial clk = 1'b0;
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // watchdog, well above the slowest legal run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: random stall before each item, sometimes none for a while
    initial
    begin
        int stall;
        result.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
            @(posedge clk);
            result.ready <= (stall == 0);
            repeat (stall) @(posedge clk);
            if (stall != 0)
                result.ready <= 1'b1;
            // ready is settled by mid cycle, so check at the falling edge
            do
                @(negedge clk);
            while (!result.valid);
        end
    end

    // write all seven registers back to back; the block is idle here
    task automatic load_regs(input logic [CFG_W-1:0] vals [7]);
        for (int i = 0; i < 7; i++)
        begin
            @(posedge clk);
            cfg_wen   <= 1'b1;
            cfg_index <= 3'(i);
            cfg_data  <= vals[i];
        end
        @(posedge clk);
        cfg_wen <= 1'b0;
    endtask

    // one item: an idle gap unless in a burst, then hold valid until the block takes it
    task automatic push_step(input logic [31:0] e, input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] sz, input logic [31:0] ex, input logic [31:0] ey,
                             input logic [31:0] ez, input bit burst);
        int gap;
        gap = burst ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            step.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        step.valid   <= 1'b1;
        step.energy  <= e;
        step.start_x <= sx;
        step.start_y <= sy;
        step.start_z <= sz;
        step.end_x   <= ex;
        step.end_y   <= ey;
        step.end_z   <= ez;
        do
            @(negedge clk);
        while (!step.ready);
        @(posedge clk);
    endtask

    // values spread over every magnitude
    function automatic logic [31:0] any_mag();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    function automatic logic [31:0] near(input logic [31:0] p);
        logic [31:0] d;
        d = $urandom >> $urandom_range(8, 31);
        return $urandom_range(0, 1) ? p + d : p - d;
    endfunction

    task automatic random_steps(input int count);
        logic [31:0] s [3];
        logic [31:0] t [3];
        bit burst;
        int kind;
        burst = 1'b0;
        for (int n = 0; n < count; n++)
        begin
            if ($urandom_range(0, 19) == 0)
                burst = !burst;
            kind = $urandom_range(0, 19);
            for (int k = 0; k < 3; k++)
            begin
                s[k] = $urandom;
                // mostly realistic short steps, some wild ones, a few zero length
                if (kind == 0)       t[k] = s[k];
                else if (kind < 4)   t[k] = $urandom;
                else if (kind < 6)   t[k] = ($urandom_range(0, 1) == 0) ? s[k] : near(s[k]);
                else                 t[k] = near(s[k]);
            end
            push_step(($urandom_range(0, 4) == 0) ? $urandom : any_mag(),
                      s[0], s[1], s[2], t[0], t[1], t[2], burst);
        end
    endtask

    // called right at the edge that took the last item
    task automatic settle();
        step.valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
    endtask

    // register sets: model, field, density, alpha, beta, scale, kb
    logic [CFG_W-1:0] setting [9][7] = '{
        '{1, 32768,    91095,   60948,  13894,   52429,  3185},
        '{0, 1,        1,       262143, 1048575, 0,      0},
        '{0, 16777215, 1048575, 0,      0,       262143, 1048575},
        '{0, 65536,    65536,   65536,  65536,   65536,  65536},
        '{1, 1,        1,       1,      1,       262143, 1048575},
        '{1, 16777215, 1048575, 0,      0,       0,      0},
        '{0, 8000,     91095,   40000,  400000,  52429,  3185},
        '{1, 200000,   91095,   60948,  13894,   262143, 100},
        '{0, 32768,    91095,   131072, 13894,   52429,  3185}
    };

    initial
    begin
        step.valid   = 1'b0;
        step.energy  = '0;
        step.start_x = '0;
        step.start_y = '0;
        step.start_z = '0;
        step.end_x   = '0;
        step.end_y   = '0;
        step.end_z   = '0;
        cfg_wen      = 1'b0;
        cfg_index    = CFG_MODEL_SELECT;
        cfg_data     = '0;
        rst_n        = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed items under the reset settings
        push_step(32'd1000000, 0, 0, 0, 0, 0, 0, 1'b0);                    // zero length
        push_step(32'hFFFF_FFFF, 0, 0, 0, 0, 0, 0, 1'b0);                  // zero length, max energy
        push_step(32'd0, 0, 0, 0, 32'h10000, 0, 0, 1'b0);                  // no energy
        push_step(32'hFFFF_FFFF, 0, 0, 0, 32'h1, 0, 0, 1'b0);              // tiny step, huge dE/dx
        push_step(32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);      // longest step
        push_step(32'd1, 32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0, 1'b1);  // negative direction
        push_step(32'h0100_0000, 0, 32'h10000, 0, 0, 0, 0, 1'b0);
        push_step(32'h0200_0000, 0, 0, 32'hFFFF_0000, 0, 0, 0, 1'b1);
        push_step(32'h0080_0000, 32'h1234, 32'h5678, 32'h9ABC, 32'h2234, 32'h5679, 32'h9ABD,
                  1'b0);
        push_step(32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 1'b1);
        push_step(32'd12345, 32'h0040_0000, 0, 0, 32'h0041_0000, 0, 0, 1'b0);
        push_step(32'h7FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                  32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0);
        random_steps(200);
        settle();

        for (int p = 0; p < 9; p++)
        begin
            load_regs(setting[p]);
            // a zero-energy item, which gives zero x, and a tiny step at max energy, under each setting
            push_step(32'd0, 0, 0, 0, 32'h10000, 0, 0, 1'b0);
            push_step(32'hFFFF_FFFF, 0, 0, 0, 32'h1, 0, 0, 1'b1);
            random_steps(190);
            settle();
        end

        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
